/* src/fwd_pkg.sv */
package fwd_pkg;

  localparam int WHEEL_COUNT = 4;
  localparam int FRAC_BITS   = 16;
  localparam int WHEEL_W     = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;
  // upper left motor is mounted reversed
  localparam int REV_WHEEL   = 1;

  localparam int CNT_W   = 16;
  localparam int CMD_W   = 32;
  localparam int GAIN_W  = 21;
  localparam int CLAMP_W = 23;
  localparam int SCALE_W = 24;
  localparam int LIMIT_W = 16;
  localparam int PWM_W   = LIMIT_W + 1;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  localparam int IN_DATA_W  = ((WHEEL_COUNT * CNT_W + 2 * CMD_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((WHEEL_COUNT * PWM_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] CFG_KP       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_KI       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_KD       = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIN  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TURN = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_SPC      = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] CFG_HT       = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = CFG_IDX_W'(7);

  localparam int KP_RESET       = -30000;
  localparam int KI_RESET       = -3000;
  localparam int KD_RESET       = -5000;
  localparam int MAX_LIN_RESET  = 6554;
  localparam int MAX_TURN_RESET = 65536;
  localparam int SPC_RESET      = 0;
  localparam int HT_RESET       = 0;
  localparam int LIMIT_RESET    = 65535;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic [CLAMP_W-1:0]       max_lin;
    logic [CLAMP_W-1:0]       max_turn;
    logic [SCALE_W-1:0]       spc;
    logic [SCALE_W-1:0]       ht;
    logic [LIMIT_W-1:0]       limit;
  } cfg_t;

  typedef struct packed {
    logic [WHEEL_COUNT-1:0][CNT_W-1:0] cnt;
    logic signed [CMD_W-1:0]           vel;
    logic signed [CMD_W-1:0]           ang;
    logic                              brake;
  } item_t;

  typedef struct packed {
    logic [WHEEL_COUNT-1:0][PWM_W-1:0] pwm;
  } res_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_stat_t;

endpackage

/* src/fwd_mul.sv */
module fwd_mul (
  input  logic                                                    clk,
  input  logic                                                    en,
  input  logic signed [fwd_pkg::CMD_W:0]                          a,
  input  logic signed [fwd_pkg::SCALE_W:0]                        b,
  output logic signed [fwd_pkg::CMD_W+fwd_pkg::SCALE_W+1:0]       prod_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

endmodule

/* src/fwd_seq.sv */
module fwd_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  fwd_pkg::item_t     item,
  input  fwd_pkg::cfg_t      cfg,
  input  logic               out_free,
  output fwd_pkg::seq_stat_t stat,
  output fwd_pkg::res_t      res
);

  localparam int W       = fwd_pkg::WHEEL_COUNT;
  localparam int WW      = fwd_pkg::WHEEL_W;
  localparam int FB      = fwd_pkg::FRAC_BITS;
  localparam int CMD_W   = fwd_pkg::CMD_W;
  localparam int CMDC_W  = fwd_pkg::CLAMP_W + 1;
  localparam int GAINN_W = fwd_pkg::GAIN_W + 1;
  localparam int MUL_A_W = CMD_W + 1;
  localparam int MUL_B_W = fwd_pkg::SCALE_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int TURN_W  = fwd_pkg::SCALE_W + CMDC_W - FB;
  localparam int MEAS_W  = fwd_pkg::CNT_W + fwd_pkg::SCALE_W;
  localparam int DIFF_W  = MEAS_W + 2;
  localparam int ERR_W   = CMD_W;
  localparam int ISUM_W  = fwd_pkg::LIMIT_W + FB + 1;
  localparam int T_W     = PROD_W + 1;
  localparam int ACC_W   = PROD_W + 2;
  localparam int SHQ_W   = ACC_W - FB;
  localparam int PWM_W   = fwd_pkg::PWM_W;

  localparam logic signed [DIFF_W-1:0] E_HI = DIFF_W'((64'sd1 <<< (ERR_W - 1)) - 64'sd1);
  localparam logic signed [DIFF_W-1:0] E_LO = -E_HI - DIFF_W'(1);

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b000_0000_0001,
    ST_TURN_MUL = 11'b000_0000_0010,
    ST_TURN_SH  = 11'b000_0000_0100,
    ST_MEAS     = 11'b000_0000_1000,
    ST_ERR      = 11'b000_0001_0000,
    ST_KI       = 11'b000_0010_0000,
    ST_ICHK     = 11'b000_0100_0000,
    ST_KP       = 11'b000_1000_0000,
    ST_KD       = 11'b001_0000_0000,
    ST_OUT      = 11'b010_0000_0000,
    ST_DONE     = 11'b100_0000_0000
  } st_t;

  function automatic logic signed [CMDC_W-1:0] clamp_cmd(
    input logic signed [CMD_W-1:0]     x,
    input logic [fwd_pkg::CLAMP_W-1:0] m
  );
    logic signed [CMD_W:0] xs;
    logic signed [CMD_W:0] ms;
    xs = (CMD_W + 1)'(x);
    ms = (CMD_W + 1)'($signed({1'b0, m}));
    if (xs > ms) begin
      return CMDC_W'(ms);
    end else if (xs < -ms) begin
      return CMDC_W'(-ms);
    end else begin
      return CMDC_W'(xs);
    end
  endfunction

  st_t                        st_r, st_nxt;
  logic [WW-1:0]              w_r, w_nxt;
  logic [W-1:0][fwd_pkg::CNT_W-1:0] cnt_r;
  logic signed [CMDC_W-1:0]   vel_r;
  logic signed [CMDC_W-1:0]   ang_r;
  logic signed [CMDC_W-1:0]   prev_turn_r;
  logic signed [TURN_W-1:0]   turn_r;
  logic signed [ERR_W-1:0]    e_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [ISUM_W-1:0]   isum_r [W];
  logic signed [ERR_W-1:0]    pe_r [W];
  logic [W-1:0][PWM_W-1:0]    pwm_r;

  logic signed [CMDC_W-1:0]   vel_c, ang_c;
  logic                       brake_hit, turn_start;
  logic                       w_last, w_left, w_rev;
  logic signed [GAINN_W-1:0]  kp_w, ki_w, kd_w;
  logic                       mul_en;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [MEAS_W-1:0]   meas;
  logic signed [DIFF_W-1:0]   tgt, diff;
  logic signed [ERR_W-1:0]    e_sat;
  logic signed [T_W-1:0]      t_sum, ibound;
  logic                       t_ok;
  logic signed [ACC_W-1:0]    acc_kp, round_bias, acc_rnd;
  logic signed [SHQ_W-1:0]    shq, lim_s;
  logic signed [PWM_W-1:0]    pwm_val;

  fwd_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  always_comb begin
    vel_c      = clamp_cmd(item.vel, cfg.max_lin);
    ang_c      = clamp_cmd(item.ang, cfg.max_turn);
    brake_hit  = (vel_c == '0) && (ang_c == '0) && item.brake;
    // integrators restart when a turn begins, checked on the raw command
    turn_start = (prev_turn_r == '0) && (item.ang != '0);

    w_last = (w_r == WW'(W - 1));
    w_left = (w_r < WW'(W / 2));
    w_rev  = (w_r == WW'(fwd_pkg::REV_WHEEL));
    kp_w   = w_rev ? -GAINN_W'(cfg.kp) : GAINN_W'(cfg.kp);
    ki_w   = w_rev ? -GAINN_W'(cfg.ki) : GAINN_W'(cfg.ki);
    kd_w   = w_rev ? -GAINN_W'(cfg.kd) : GAINN_W'(cfg.kd);

    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (st_r)
      ST_TURN_MUL: begin
        mul_a = MUL_A_W'(ang_r);
        mul_b = MUL_B_W'($signed({1'b0, cfg.ht}));
      end
      ST_MEAS: begin
        mul_a = MUL_A_W'($signed(cnt_r[w_r]));
        mul_b = MUL_B_W'($signed({1'b0, cfg.spc}));
      end
      ST_KI: begin
        mul_a = MUL_A_W'(e_r);
        mul_b = MUL_B_W'(ki_w);
      end
      ST_ICHK: begin
        mul_a = MUL_A_W'(e_r);
        mul_b = MUL_B_W'(kp_w);
      end
      ST_KP: begin
        mul_a = MUL_A_W'(e_r) - MUL_A_W'(pe_r[w_r]);
        mul_b = MUL_B_W'(kd_w);
      end
      default: mul_en = 1'b0;
    endcase

    meas = $signed(prod[MEAS_W-1:0]);
    tgt  = w_left ? (DIFF_W'(vel_r) - DIFF_W'(turn_r)) : (DIFF_W'(vel_r) + DIFF_W'(turn_r));
    diff = tgt - DIFF_W'(meas);
    if (diff > E_HI) begin
      e_sat = ERR_W'(E_HI);
    end else if (diff < E_LO) begin
      e_sat = ERR_W'(E_LO);
    end else begin
      e_sat = ERR_W'(diff);
    end

    t_sum  = T_W'(prod) + T_W'(isum_r[w_r]);
    ibound = T_W'($signed({1'b0, cfg.limit, {FB{1'b0}}}));
    t_ok   = (t_sum <= ibound) && (t_sum >= -ibound);

    acc_kp = ACC_W'(prod) + ACC_W'(isum_r[w_r]);

    // shift toward zero: bias negatives by one LSB short of a unit
    round_bias         = '0;
    round_bias[FB-1:0] = {FB{acc_r[ACC_W-1]}};
    acc_rnd            = acc_r + round_bias;
    shq                = $signed(acc_rnd[ACC_W-1:FB]);
    lim_s              = SHQ_W'($signed({1'b0, cfg.limit}));
    if (shq > lim_s) begin
      pwm_val = PWM_W'(lim_s);
    end else if (shq < -lim_s) begin
      pwm_val = PWM_W'(-lim_s);
    end else begin
      pwm_val = PWM_W'(shq);
    end
  end

  always_comb begin
    st_nxt = st_r;
    w_nxt  = w_r;
    case (st_r)
      ST_IDLE: begin
        if (start) begin
          st_nxt = brake_hit ? ST_DONE : ST_TURN_MUL;
        end
      end
      ST_TURN_MUL: st_nxt = ST_TURN_SH;
      ST_TURN_SH: begin
        st_nxt = ST_MEAS;
        w_nxt  = '0;
      end
      ST_MEAS: st_nxt = ST_ERR;
      ST_ERR:  st_nxt = ST_KI;
      ST_KI:   st_nxt = ST_ICHK;
      ST_ICHK: st_nxt = ST_KP;
      ST_KP:   st_nxt = ST_KD;
      ST_KD:   st_nxt = ST_OUT;
      ST_OUT: begin
        if (w_last) begin
          st_nxt = ST_DONE;
        end else begin
          st_nxt = ST_MEAS;
          w_nxt  = w_r + WW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      w_r         <= '0;
      prev_turn_r <= '0;
      for (int i = 0; i < W; i++) begin
        isum_r[i] <= '0;
        pe_r[i]   <= '0;
      end
    end else begin
      st_r <= st_nxt;
      w_r  <= w_nxt;
      if (st_r == ST_IDLE && start) begin
        prev_turn_r <= ang_c;
        if (turn_start) begin
          for (int i = 0; i < W; i++) begin
            isum_r[i] <= '0;
          end
        end
      end
      if (st_r == ST_ICHK && t_ok) begin
        isum_r[w_r] <= ISUM_W'(t_sum);
      end
      if (st_r == ST_KD) begin
        pe_r[w_r] <= e_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && start) begin
      cnt_r <= item.cnt;
      vel_r <= vel_c;
      ang_r <= ang_c;
      if (brake_hit) begin
        pwm_r <= '0;
      end
    end
    if (st_r == ST_TURN_SH) begin
      turn_r <= $signed(prod[FB +: TURN_W]);
    end
    if (st_r == ST_ERR) begin
      e_r <= e_sat;
    end
    if (st_r == ST_KP) begin
      acc_r <= acc_kp;
    end
    if (st_r == ST_KD) begin
      acc_r <= acc_r + ACC_W'(prod);
    end
    if (st_r == ST_OUT) begin
      pwm_r[w_r] <= pwm_val;
    end
  end

  assign stat.idle = (st_r == ST_IDLE);
  assign stat.done = (st_r == ST_DONE);
  assign res.pwm   = pwm_r;

`ifndef ASSERT_OFF
  a_brake_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE && start && brake_hit) |=> (st_r == ST_DONE))
    else $error("brake request did not skip the wheel loop");

  a_last_wheel: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_OUT && w_last) |=> (st_r == ST_DONE))
    else $error("sequencer ran past the last wheel");

  a_prev_err: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_KD) |=> (pe_r[$past(w_r)] == $past(e_r)))
    else $error("previous error not stored for wheel");

  for (genvar g = 0; g < W; g++) begin : g_pwm_chk
    a_pwm_range: assert property (@(posedge clk) disable iff (!rst_n)
      (st_r == ST_DONE) |->
        (($signed(pwm_r[g]) <= $signed({1'b0, cfg.limit})) &&
         ($signed(pwm_r[g]) >= -$signed({1'b0, cfg.limit}))))
      else $error("drive value outside limit");
  end
`endif

endmodule

/* src/four_wheel_differential_speed_pid_unit.sv */
// From input accept to out_tvalid: the turn offset (TURN_MUL, TURN_SH), then per wheel MEAS, ERR,
// KI, ICHK, KP, KD and OUT through the one shared multiplier, then DONE loads the output register.
// A brake request skips to DONE. No new request is taken until the last is done: the input waits
// while the wheel loop runs or while a finished result is still held by the output register.
// Reset (rst_n low at a clock edge): integrators, previous errors and the previous turn command
// clear to zero, configuration registers return to their defaults, the output register empties.
module four_wheel_differential_speed_pid_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // count_lower_left, count_upper_left, count_lower_right, count_upper_right,
  // velocity_command, angular_command
  input  logic [fwd_pkg::IN_DATA_W-1:0]    in_tdata,
  // brake
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // pwm_lower_left, pwm_upper_left, pwm_lower_right, pwm_upper_right, zero pad
  output logic [fwd_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fwd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fwd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int W = fwd_pkg::WHEEL_COUNT;

  fwd_pkg::cfg_t      cfg_r;
  fwd_pkg::item_t     item;
  fwd_pkg::seq_stat_t stat;
  fwd_pkg::res_t      res;
  fwd_pkg::res_t      out_data_r;
  logic               out_valid_r;
  logic               start, out_free;

  always_comb begin
    for (int i = 0; i < W; i++) begin
      item.cnt[i] = in_tdata[i*fwd_pkg::CNT_W +: fwd_pkg::CNT_W];
    end
    item.vel   = $signed(in_tdata[W*fwd_pkg::CNT_W +: fwd_pkg::CMD_W]);
    item.ang   = $signed(in_tdata[W*fwd_pkg::CNT_W + fwd_pkg::CMD_W +: fwd_pkg::CMD_W]);
    item.brake = in_tuser;
  end

  assign in_tready = stat.idle;
  assign start     = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp       <= fwd_pkg::GAIN_W'(fwd_pkg::KP_RESET);
      cfg_r.ki       <= fwd_pkg::GAIN_W'(fwd_pkg::KI_RESET);
      cfg_r.kd       <= fwd_pkg::GAIN_W'(fwd_pkg::KD_RESET);
      cfg_r.max_lin  <= fwd_pkg::CLAMP_W'(fwd_pkg::MAX_LIN_RESET);
      cfg_r.max_turn <= fwd_pkg::CLAMP_W'(fwd_pkg::MAX_TURN_RESET);
      cfg_r.spc      <= fwd_pkg::SCALE_W'(fwd_pkg::SPC_RESET);
      cfg_r.ht       <= fwd_pkg::SCALE_W'(fwd_pkg::HT_RESET);
      cfg_r.limit    <= fwd_pkg::LIMIT_W'(fwd_pkg::LIMIT_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fwd_pkg::CFG_KP:       cfg_r.kp       <= $signed(cfg_data[fwd_pkg::GAIN_W-1:0]);
        fwd_pkg::CFG_KI:       cfg_r.ki       <= $signed(cfg_data[fwd_pkg::GAIN_W-1:0]);
        fwd_pkg::CFG_KD:       cfg_r.kd       <= $signed(cfg_data[fwd_pkg::GAIN_W-1:0]);
        fwd_pkg::CFG_MAX_LIN:  cfg_r.max_lin  <= cfg_data[fwd_pkg::CLAMP_W-1:0];
        fwd_pkg::CFG_MAX_TURN: cfg_r.max_turn <= cfg_data[fwd_pkg::CLAMP_W-1:0];
        fwd_pkg::CFG_SPC:      cfg_r.spc      <= cfg_data[fwd_pkg::SCALE_W-1:0];
        fwd_pkg::CFG_HT:       cfg_r.ht       <= cfg_data[fwd_pkg::SCALE_W-1:0];
        fwd_pkg::CFG_LIMIT:    cfg_r.limit    <= cfg_data[fwd_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  fwd_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .item     (item),
    .cfg      (cfg_r),
    .out_free (out_free),
    .stat     (stat),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.done && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done && out_free) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = fwd_pkg::OUT_DATA_W'(out_data_r.pwm);

endmodule
